// File: src/lra_pkg.sv
`timescale 1ns / 1ps

package lra_pkg;

    // Mode codes.
    localparam logic [2:0] M_OFF      = 3'd0;
    localparam logic [2:0] M_BOOT     = 3'd1;
    localparam logic [2:0] M_IDLE     = 3'd2;
    localparam logic [2:0] M_STARTING = 3'd3;
    localparam logic [2:0] M_RUN      = 3'd4;
    localparam logic [2:0] M_WAYPOINT = 3'd5;
    localparam logic [2:0] M_ERROR    = 3'd6;
    localparam logic [2:0] M_MANUAL   = 3'd7;

    // Action codes of an input request.
    localparam logic [2:0] A_TICK         = 3'd0;
    localparam logic [2:0] A_SET_ACTIVE   = 3'd1;
    localparam logic [2:0] A_SET_ERROR    = 3'd2;
    localparam logic [2:0] A_WAYPOINT     = 3'd3;
    localparam logic [2:0] A_SET_MANUAL   = 3'd4;
    localparam logic [2:0] A_CLEAR_MANUAL = 3'd5;
    localparam logic [2:0] A_FORCE_MODE   = 3'd6;

    // Frame layout codes handed from the front end to the LED sequencer.
    localparam logic [1:0] K_ALL = 2'd0;   // every LED shows colour A
    localparam logic [1:0] K_ODD = 2'd1;   // even LEDs colour A, odd LEDs colour B
    localparam logic [1:0] K_ONE = 2'd2;   // one LED shows colour A, the rest black

    // Timing constants in milliseconds.
    localparam int FRAME_GAP    = 16;
    localparam int BOOT_SPAN    = 800;
    localparam int FLASH_ON     = 120;
    localparam int FLASH_PERIOD = 200;
    localparam int FLASH_TOTAL  = 1000;
    localparam int GATE_SPAN    = 1150;
    localparam int BLINK_HALF   = 250;
    localparam int CHASE_STEP   = 50;
    localparam int BEAT_PERIOD  = 1300;

    // Heartbeat envelope.
    localparam int BEAT_RISE_END = 150;
    localparam int BEAT_DIP_END  = 250;
    localparam int BEAT_BUMP_END = 350;
    localparam int BEAT_FALL_END = 500;
    localparam int BEAT_PEAK     = 220;
    localparam int BEAT_DIP      = 20;
    localparam int BEAT_REST     = 5;
    localparam int BEAT_RISE_MUL = 22;    // 220/150 = 22/15
    localparam int BEAT_FALL_MUL = 43;    // 215/150 = 43/30, halved first

    // Reciprocals for small exact divisions, scaled by 2^RECIP_SHIFT.
    // Exact for numerators below 4681, which covers every use here.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_15    = 4370;
    localparam int RECIP_50    = 1311;

    localparam int BOOT_BASE = 20;

    // Widths.
    localparam int DIVIDEND_W  = 32;
    localparam int DIVISOR_W   = 12;      // largest divisor is 50 * 64
    localparam int NUM_W       = 12;
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int CHASE_W     = 6;       // LED index of a chase, up to 64 LEDs
    localparam int QUEUE_DEPTH = 2;

    // First quadrant of a rounded 8-bit sine.
    localparam logic [6:0] QUARTER_SINE [65] = '{
        7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
        7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
        7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
        7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
        7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
        7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
        7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
        7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
        7'd127
    };

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_ms;
        logic        flag;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [7:0]  pattern;
        logic [2:0]  forced_mode;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  led_index;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        last;
        logic [31:0] gate_deadline;
    } t_out_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // One frame as the LED sequencer needs it.
    typedef struct packed {
        logic [1:0]         kind;
        t_rgb               col_a;
        t_rgb               col_b;
        logic [CHASE_W-1:0] idx;
        logic [31:0]        gate;
    } t_frame;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quot;
        logic [DIVISOR_W-1:0]  rem;
    } t_div_rsp;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] start;
        logic [31:0] gate;
    } t_entry;

    // Rounded sine over a 256-step circle, 1..255.
    function automatic logic [7:0] sine8(input logic [7:0] x);
        logic [6:0] idx;
        logic [6:0] m;
        idx = x[6] ? 7'(7'd64 - {1'b0, x[5:0]}) : {1'b0, x[5:0]};
        m   = QUARTER_SINE[idx];
        return x[7] ? 8'(8'd128 - {1'b0, m}) : 8'(8'd128 + {1'b0, m});
    endfunction

    // Mode entry: stamps the start time and sets the sensor gate.
    function automatic t_entry enter_mode(input logic [2:0] m, input logic [31:0] now);
        t_entry e;
        e.mode  = m;
        e.start = now;
        e.gate  = (m == M_WAYPOINT || m == M_STARTING) ? now + 32'(GATE_SPAN) : '0;
        return e;
    endfunction

    // Mode that the wishes call for.
    function automatic logic [2:0] auto_mode(input logic werr, input logic wact);
        return werr ? M_ERROR : (wact ? M_RUN : M_IDLE);
    endfunction

endpackage

// File: src/lra_if.sv
`timescale 1ns / 1ps

// Input request channel.
interface lra_in_if;
    logic              valid;
    logic              ready;
    lra_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Output colour channel.
interface lra_out_if;
    logic               valid;
    logic               ready;
    lra_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/lra_div.sv
`timescale 1ns / 1ps

// Restoring divider, two quotient bits per cycle.
module lra_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lra_pkg::t_div_req i_req,
    output lra_pkg::t_div_rsp o_rsp
);
    import lra_pkg::*;

    localparam int ITER   = DIVIDEND_W / 2;
    localparam int STEP_W = $clog2(ITER);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [DIVIDEND_W-1:0] r_dvd;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    trial1;
    logic [DIVISOR_W:0]    trial2;
    logic                  ge1;
    logic                  ge2;
    logic [DIVISOR_W-1:0]  rem1;
    logic [DIVISOR_W-1:0]  rem2;

    // Two dependent compare and subtract steps on the partial remainder.
    always_comb begin
        trial1 = {r_rem, r_dvd[DIVIDEND_W-1]};
        ge1    = trial1 >= {1'b0, r_dvs};
        rem1   = ge1 ? DIVISOR_W'(trial1 - {1'b0, r_dvs}) : DIVISOR_W'(trial1);
        trial2 = {rem1, r_dvd[DIVIDEND_W-2]};
        ge2    = trial2 >= {1'b0, r_dvs};
        rem2   = ge2 ? DIVISOR_W'(trial2 - {1'b0, r_dvs}) : DIVISOR_W'(trial2);
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend register fills with quotient bits from the bottom.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIVIDEND_W-3:0], ge1, ge2};
            r_rem <= rem2;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dvd;
    assign o_rsp.rem  = r_rem;

endmodule

// File: src/lra_front.sv
`timescale 1ns / 1ps

// Front end: takes requests, keeps the mode state and builds frame descriptors.
module lra_front #(
    parameter int LED_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lra_in_if.sink            i_in,
    output lra_pkg::t_div_req o_div_req,
    input  lra_pkg::t_div_rsp i_div_rsp,
    output logic              o_push,
    output lra_pkg::t_frame   o_frame,
    input  logic              i_full
);
    import lra_pkg::*;

    localparam int CHASE_SPAN = CHASE_STEP * LED_COUNT;

    localparam logic [2:0] S_READY = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;

    logic [2:0]        r_state,  n_state;
    logic [2:0]        r_mode,   n_mode;
    logic [31:0]       r_mode_start, n_mode_start;
    logic [31:0]       r_last_frame, n_last_frame;
    logic [31:0]       r_gate,   n_gate;
    logic              r_wish_active, n_wish_active;
    logic              r_wish_error,  n_wish_error;
    t_rgb              r_man,    n_man;
    logic [7:0]        r_man_pattern, n_man_pattern;
    logic [NUM_W-1:0]  r_num,    n_num;
    logic [PROD_W-1:0] r_prod,   n_prod;

    t_in_item          item;
    logic              accept;
    logic [31:0]       elapsed;
    logic [31:0]       t_mode;
    logic              do_enter;
    logic [2:0]        enter_m;
    t_entry            entry;
    logic              div_start;

    logic [DIVISOR_W-1:0] p;
    logic [15:0]          rise_full;
    logic [11:0]          p_off;
    logic [17:0]          fall_full;
    logic [RECIP_W-1:0]   recip;
    logic [7:0]           q_small;
    logic [11:0]          beat_w;
    logic [7:0]           beat;
    logic [7:0]           boot_v;
    logic                 blink_on;

    assign item        = i_in.data;
    assign i_in.ready  = (r_state == S_READY);
    assign accept      = i_in.valid && i_in.ready;
    assign elapsed     = item.now_ms - r_last_frame;
    assign t_mode      = item.now_ms - r_mode_start;

    // Request decode, mode changes and sequencing.
    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_mode_start  = r_mode_start;
        n_last_frame  = r_last_frame;
        n_gate        = r_gate;
        n_wish_active = r_wish_active;
        n_wish_error  = r_wish_error;
        n_man         = r_man;
        n_man_pattern = r_man_pattern;
        do_enter      = 1'b0;
        enter_m       = r_mode;
        div_start     = 1'b0;

        unique case (r_state)
            S_READY: begin
                if (accept) begin
                    unique case (item.action)
                        A_TICK: begin
                            if (elapsed >= 32'(FRAME_GAP)) begin
                                n_last_frame = item.now_ms;
                                if (r_mode == M_BOOT && t_mode >= 32'(BOOT_SPAN)) begin
                                    do_enter = 1'b1;
                                    enter_m  = r_wish_error ? M_ERROR :
                                               (r_wish_active ? M_STARTING : M_IDLE);
                                end else if (r_mode == M_STARTING &&
                                             t_mode >= 32'(FLASH_TOTAL)) begin
                                    do_enter = 1'b1;
                                    enter_m  = M_RUN;
                                end else if (r_mode == M_WAYPOINT &&
                                             t_mode >= 32'(FLASH_TOTAL)) begin
                                    do_enter = 1'b1;
                                    enter_m  = auto_mode(r_wish_error, r_wish_active);
                                end else begin
                                    div_start = 1'b1;
                                    n_state   = S_DIV;
                                end
                            end
                        end
                        A_SET_ACTIVE: begin
                            n_wish_active = item.flag;
                            if (r_mode == M_IDLE && item.flag) begin
                                do_enter = 1'b1;
                                enter_m  = M_STARTING;
                            end else if (r_mode == M_RUN && !item.flag) begin
                                do_enter = 1'b1;
                                enter_m  = M_IDLE;
                            end
                        end
                        A_SET_ERROR: begin
                            n_wish_error = item.flag;
                            if (r_mode != M_MANUAL) begin
                                if (item.flag && r_mode != M_ERROR) begin
                                    do_enter = 1'b1;
                                    enter_m  = M_ERROR;
                                end else if (!item.flag && r_mode == M_ERROR) begin
                                    do_enter = 1'b1;
                                    enter_m  = auto_mode(1'b0, r_wish_active);
                                end
                            end
                        end
                        A_WAYPOINT: begin
                            if (r_mode != M_ERROR && r_mode != M_MANUAL) begin
                                do_enter = 1'b1;
                                enter_m  = M_WAYPOINT;
                            end
                        end
                        A_SET_MANUAL: begin
                            n_man.red     = item.red_in;
                            n_man.green   = item.green_in;
                            n_man.blue    = item.blue_in;
                            n_man_pattern = item.pattern;
                            do_enter      = 1'b1;
                            enter_m       = M_MANUAL;
                        end
                        A_CLEAR_MANUAL: begin
                            if (r_mode == M_MANUAL) begin
                                do_enter = 1'b1;
                                enter_m  = auto_mode(r_wish_error, r_wish_active);
                            end
                        end
                        A_FORCE_MODE: begin
                            do_enter = 1'b1;
                            enter_m  = item.forced_mode;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_PUSH;
            S_PUSH: begin
                if (!i_full) begin
                    n_state = S_READY;
                end
            end
            default: n_state = S_READY;
        endcase

        entry = enter_mode(enter_m, item.now_ms);
        if (do_enter) begin
            n_mode       = entry.mode;
            n_mode_start = entry.start;
            n_gate       = entry.gate;
        end
    end

    // Division request for the animation phase of the current mode.
    always_comb begin
        o_div_req.start    = div_start;
        o_div_req.dividend = t_mode;
        o_div_req.divisor  = DIVISOR_W'(BLINK_HALF);
        unique case (r_mode)
            M_BOOT: begin
                o_div_req.dividend = {t_mode[23:0], 8'h00};
                o_div_req.divisor  = DIVISOR_W'(BOOT_SPAN);
            end
            M_IDLE: o_div_req.divisor = DIVISOR_W'(BEAT_PERIOD);
            M_STARTING, M_WAYPOINT: o_div_req.divisor = DIVISOR_W'(FLASH_PERIOD);
            M_MANUAL: begin
                if (r_man_pattern > 8'd1) begin
                    o_div_req.divisor = DIVISOR_W'(CHASE_SPAN);
                end
            end
            default: o_div_req.divisor = DIVISOR_W'(BLINK_HALF);
        endcase
    end

    // Numerator for the small reciprocal division: heartbeat slopes or chase step.
    assign p         = i_div_rsp.rem;
    assign rise_full = {4'd0, p} * 16'(BEAT_RISE_MUL);
    assign p_off     = 12'(p) - 12'(BEAT_BUMP_END);
    assign fall_full = {6'd0, p_off} * 18'(BEAT_FALL_MUL);

    always_comb begin
        if (r_mode == M_IDLE) begin
            n_num = (p < DIVISOR_W'(BEAT_RISE_END)) ? rise_full[NUM_W-1:0] : fall_full[NUM_W:1];
        end else begin
            n_num = NUM_W'(p);
        end
        recip  = (r_mode == M_IDLE) ? RECIP_W'(RECIP_15) : RECIP_W'(RECIP_50);
        n_prod = {{RECIP_W{1'b0}}, r_num} * {{NUM_W{1'b0}}, recip};
    end

    // Heartbeat level, boot grey and blink phase.
    assign q_small  = r_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    assign boot_v   = 8'((sine8(i_div_rsp.quot[7:0]) >> 2) + 8'(BOOT_BASE));
    assign blink_on = !i_div_rsp.quot[0];

    always_comb begin
        if (p < DIVISOR_W'(BEAT_RISE_END)) begin
            beat_w = {4'd0, q_small};
        end else if (p < DIVISOR_W'(BEAT_DIP_END)) begin
            beat_w = 12'(BEAT_PEAK) - ((12'(p) - 12'(BEAT_RISE_END)) << 1);
        end else if (p < DIVISOR_W'(BEAT_BUMP_END)) begin
            beat_w = 12'(BEAT_DIP) + ((12'(p) - 12'(BEAT_DIP_END)) << 1);
        end else if (p < DIVISOR_W'(BEAT_FALL_END)) begin
            beat_w = 12'(BEAT_PEAK) - {4'd0, q_small};
        end else begin
            beat_w = 12'(BEAT_REST);
        end
        beat = beat_w[7:0];
    end

    // Frame descriptor.
    always_comb begin
        o_frame.kind  = K_ALL;
        o_frame.col_a = '0;
        o_frame.col_b = '0;
        o_frame.idx   = q_small[CHASE_W-1:0];
        o_frame.gate  = r_gate;
        unique case (r_mode)
            M_BOOT: o_frame.col_a = '{red: boot_v, green: boot_v, blue: boot_v};
            M_IDLE: o_frame.col_a = '{red: 8'd0, green: 8'd0, blue: beat};
            M_STARTING, M_WAYPOINT: begin
                o_frame.col_a = '{red: 8'd255, green: 8'd255, blue: 8'd255};
                if (p < DIVISOR_W'(FLASH_ON)) begin
                    o_frame.kind  = K_ODD;
                    o_frame.col_b = (r_mode == M_STARTING) ?
                                    '{red: 8'd0, green: 8'd220, blue: 8'd0} :
                                    '{red: 8'd255, green: 8'd200, blue: 8'd0};
                end
            end
            M_RUN: o_frame.col_a = '{red: 8'd255, green: 8'd255, blue: 8'd255};
            M_ERROR: o_frame.col_a = '{red: blink_on ? 8'd255 : 8'd0, green: 8'd0, blue: 8'd0};
            M_MANUAL: begin
                if (r_man_pattern == 8'd0) begin
                    o_frame.col_a = r_man;
                end else if (r_man_pattern == 8'd1) begin
                    o_frame.col_a = blink_on ? r_man : '0;
                end else begin
                    o_frame.kind  = K_ONE;
                    o_frame.col_a = r_man;
                end
            end
            default: o_frame.col_a = '0;
        endcase
    end

    assign o_push = (r_state == S_PUSH) && !i_full;

    // Control and mode state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_READY;
            r_mode        <= M_BOOT;
            r_mode_start  <= '0;
            r_last_frame  <= '0;
            r_gate        <= '0;
            r_wish_active <= 1'b0;
            r_wish_error  <= 1'b0;
            r_man         <= '0;
            r_man_pattern <= '0;
        end else begin
            r_state       <= n_state;
            r_mode        <= n_mode;
            r_mode_start  <= n_mode_start;
            r_last_frame  <= n_last_frame;
            r_gate        <= n_gate;
            r_wish_active <= n_wish_active;
            r_wish_error  <= n_wish_error;
            r_man         <= n_man;
            r_man_pattern <= n_man_pattern;
        end
    end

    // Multiplier pipeline registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL1) begin
            r_num <= n_num;
        end
        if (r_state == S_MUL2) begin
            r_prod <= n_prod;
        end
    end

    // The sequencer waits for the divider until it reports completion.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_div_rsp.done) |=> r_state == S_DIV)
        else $error("front end left the divide step early");

    // An event request never occupies the front end beyond its own cycle.
    a_event_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && item.action != A_TICK) |=> r_state == S_READY)
        else $error("event request did not complete in one cycle");

    // A tick that comes too soon leaves mode and frame time alone.
    a_close_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && item.action == A_TICK && elapsed < 32'(FRAME_GAP))
        |=> ($stable(r_mode) && $stable(r_last_frame)))
        else $error("close tick changed state");

    // A frame is queued once and the front end then frees itself.
    a_push_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_state == S_READY))
        else $error("front end stayed busy after queuing a frame");

endmodule

// File: src/lra_fifo.sv
`timescale 1ns / 1ps

// Short queue of frame descriptors between the front end and the LED sequencer.
module lra_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lra_pkg::t_frame i_data,
    output logic            o_full,
    input  logic            i_pop,
    output lra_pkg::t_frame o_data,
    output logic            o_empty
);
    import lra_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: src/lra_back.sv
`timescale 1ns / 1ps

// LED sequencer: turns one frame descriptor into one colour per LED.
module lra_back #(
    parameter int LED_COUNT = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lra_pkg::t_frame i_frame,
    input  logic            i_empty,
    output logic            o_pop,
    lra_out_if.source       o_out
);
    import lra_pkg::*;

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    logic             r_busy;
    logic [IDX_W-1:0] r_cnt;
    t_frame           r_desc;
    logic             r_ovalid;
    t_out_item        r_odata;

    logic             load;
    logic             is_last;
    t_rgb             colour;
    logic [31:0]      idx_wide;

    assign load     = r_busy && (!r_ovalid || o_out.ready);
    assign is_last  = (r_cnt == IDX_W'(LED_COUNT - 1));
    assign o_pop    = !i_empty && (!r_busy || (load && is_last));
    assign idx_wide = 32'(r_cnt);

    // Colour of the LED in hand.
    always_comb begin
        unique case (r_desc.kind)
            K_ALL: colour = r_desc.col_a;
            K_ODD: colour = r_cnt[0] ? r_desc.col_b : r_desc.col_a;
            K_ONE: colour = (CHASE_W'(r_cnt) == r_desc.idx) ? r_desc.col_a : '0;
            default: colour = '0;
        endcase
    end

    // Frame walk and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (load) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Descriptor and output payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_frame;
        end
        if (load) begin
            r_odata.led_index     <= idx_wide[3:0];
            r_odata.red_out       <= colour.red;
            r_odata.green_out     <= colour.green;
            r_odata.blue_out      <= colour.blue;
            r_odata.last          <= is_last;
            r_odata.gate_deadline <= r_desc.gate;
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // After the final LED with nothing queued the sequencer goes quiet.
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && is_last && !o_pop) |=> !r_busy)
        else $error("sequencer kept running past the last LED");

    // A new frame always starts from the first LED.
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_busy && r_cnt == '0))
        else $error("new frame did not start at the first LED");

    // Within a frame the LED index advances by one per emitted colour.
    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !is_last && !o_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("LED index skipped or repeated");

endmodule

// File: src/led_ring_status_animator_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// i_in      in   i_in.valid/ready     action, now_ms, flag, manual colour, pattern, mode
// o_out     out  o_out.valid/ready    led_index, colours, last, gate_deadline
//
// An event request is taken without leaving the ready state, as is a tick that is too
// close or ends a timed mode. A tick that draws a frame holds the input while it passes
// the two-bit-per-cycle divider that finds the animation phase, then two multiplier
// stages and the queue write. The frame then leaves at one LED per cycle while the output
// is ready, from a two-entry queue, so a stalled output holds back the input only once the
// queue is full. Reset is synchronous and active low; the block is ready once it is released.
module led_ring_status_animator_top #(
    parameter int LED_COUNT = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lra_in_if.sink    i_in,
    lra_out_if.source o_out
);
    import lra_pkg::*;

    t_div_req div_req;
    t_div_rsp div_rsp;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    t_frame   q_in;
    t_frame   q_out;

    // Request decode and frame set-up.
    lra_front #(
        .LED_COUNT (LED_COUNT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .o_push    (q_push),
        .o_frame   (q_in),
        .i_full    (q_full)
    );

    // Phase divider.
    lra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Frame queue.
    lra_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // Per-LED colour output.
    lra_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (q_out),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

// File: tb/sv/led_ring_status_animator_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the LED ring animator. Each accepted request
// updates a local copy of the animator state and queues the colours that
// the request should produce. Each accepted colour is compared with the
// oldest queued one.
module led_ring_status_animator_checker
    import lra_pkg::*;
#(
    parameter int LED_COUNT = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lra_in_if    i_req_ch,
    lra_out_if   i_led_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_frames
);

    // Timing of the animations, in milliseconds.
    localparam logic [31:0] TICK_SPACING = 32'd16;
    localparam logic [31:0] BOOT_LENGTH  = 32'd800;
    localparam logic [31:0] FLASH_LENGTH = 32'd1000;
    localparam logic [31:0] FLASH_CYCLE  = 32'd200;
    localparam logic [31:0] FLASH_LIT    = 32'd120;
    localparam logic [31:0] GATE_LENGTH  = 32'd1150;
    localparam logic [31:0] BLINK_STEP   = 32'd250;
    localparam logic [31:0] CHASE_PERIOD = 32'd50;

    // First quarter of the rounded 8-bit sine wave.
    localparam logic [6:0] SINE_QUADRANT [65] = '{
        7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
        7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
        7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
        7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
        7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
        7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
        7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
        7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
        7'd127
    };

    // Local copy of the animator state.
    logic [2:0]  ring_mode;
    logic [31:0] mode_since_ms;
    logic [31:0] last_tick_ms;
    logic [31:0] sensor_gate_ms;
    logic        want_active;
    logic        want_error;
    logic [7:0]  hand_red;
    logic [7:0]  hand_green;
    logic [7:0]  hand_blue;
    logic [7:0]  hand_pattern;

    t_out_item   colour_q[$];
    t_out_item   got_colour;
    t_out_item   due_colour;

    // Rounded sine over a circle of 256 steps.
    function automatic logic [7:0] ring_sine(input logic [7:0] x);
        logic [6:0] idx;
        logic [6:0] m;
        idx = x[6] ? 7'(7'd64 - {1'b0, x[5:0]}) : {1'b0, x[5:0]};
        m   = SINE_QUADRANT[idx];
        return x[7] ? 8'(8'd128 - {1'b0, m}) : 8'(8'd128 + {1'b0, m});
    endfunction

    // Blue level of the idle heartbeat, which repeats every 1300 ms.
    function automatic logic [7:0] beat_level(input logic [31:0] el);
        logic [31:0] p;
        logic [31:0] v;
        p = el % 32'd1300;
        if (p < 32'd150) begin
            v = (p * 32'd220) / 32'd150;
        end else if (p < 32'd250) begin
            v = 32'd220 - ((p - 32'd150) * 32'd200) / 32'd100;
        end else if (p < 32'd350) begin
            v = 32'd20 + ((p - 32'd250) * 32'd200) / 32'd100;
        end else if (p < 32'd500) begin
            v = 32'd220 - ((p - 32'd350) * 32'd215) / 32'd150;
        end else begin
            v = 32'd5;
        end
        return v[7:0];
    endfunction

    // Entering a mode restarts its clock and sets or clears the sensor gate.
    function automatic void switch_mode(input logic [2:0] m, input logic [31:0] now);
        ring_mode     = m;
        mode_since_ms = now;
        if (m == M_WAYPOINT || m == M_STARTING) begin
            sensor_gate_ms = now + GATE_LENGTH;
        end else begin
            sensor_gate_ms = '0;
        end
    endfunction

    // Mode chosen by the stored wishes.
    function automatic logic [2:0] wished_mode();
        return want_error ? M_ERROR : (want_active ? M_RUN : M_IDLE);
    endfunction

    // Updates the state for one request and queues the frame it draws, if any.
    task automatic predict_request(input t_in_item req);
        logic [31:0] el;
        logic [31:0] phase;
        logic [7:0]  level;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic        lit;
        t_out_item   col;

        if (req.action != A_TICK) begin
            case (req.action)
                A_SET_ACTIVE: begin
                    want_active = req.flag;
                    if (ring_mode == M_IDLE && req.flag) begin
                        switch_mode(M_STARTING, req.now_ms);
                    end else if (ring_mode == M_RUN && !req.flag) begin
                        switch_mode(M_IDLE, req.now_ms);
                    end
                end
                A_SET_ERROR: begin
                    want_error = req.flag;
                    if (ring_mode != M_MANUAL) begin
                        if (req.flag && ring_mode != M_ERROR) begin
                            switch_mode(M_ERROR, req.now_ms);
                        end else if (!req.flag && ring_mode == M_ERROR) begin
                            switch_mode(wished_mode(), req.now_ms);
                        end
                    end
                end
                A_WAYPOINT: begin
                    if (ring_mode != M_ERROR && ring_mode != M_MANUAL) begin
                        switch_mode(M_WAYPOINT, req.now_ms);
                    end
                end
                A_SET_MANUAL: begin
                    hand_red     = req.red_in;
                    hand_green   = req.green_in;
                    hand_blue    = req.blue_in;
                    hand_pattern = req.pattern;
                    switch_mode(M_MANUAL, req.now_ms);
                end
                A_CLEAR_MANUAL: begin
                    if (ring_mode == M_MANUAL) begin
                        switch_mode(wished_mode(), req.now_ms);
                    end
                end
                A_FORCE_MODE: begin
                    switch_mode(req.forced_mode, req.now_ms);
                end
                default: begin
                end
            endcase
            return;
        end

        // A tick too close to the previous accepted one is dropped.
        if (req.now_ms - last_tick_ms < TICK_SPACING) begin
            return;
        end
        last_tick_ms = req.now_ms;
        el = req.now_ms - mode_since_ms;

        // Timed modes that have run out move on and draw nothing.
        if (ring_mode == M_BOOT && el >= BOOT_LENGTH) begin
            if (want_error) begin
                switch_mode(M_ERROR, req.now_ms);
            end else if (want_active) begin
                switch_mode(M_STARTING, req.now_ms);
            end else begin
                switch_mode(M_IDLE, req.now_ms);
            end
            return;
        end
        if (ring_mode == M_STARTING && el >= FLASH_LENGTH) begin
            switch_mode(M_RUN, req.now_ms);
            return;
        end
        if (ring_mode == M_WAYPOINT && el >= FLASH_LENGTH) begin
            switch_mode(wished_mode(), req.now_ms);
            return;
        end

        level = '0;
        if (ring_mode == M_BOOT) begin
            phase = el * 32'd256;
            level = (ring_sine(8'(phase / BOOT_LENGTH)) >> 2) + 8'd20;
        end else if (ring_mode == M_IDLE) begin
            level = beat_level(el);
        end

        // One colour per LED.
        for (int i = 0; i < LED_COUNT; i++) begin
            r = '0;
            g = '0;
            b = '0;
            case (ring_mode)
                M_BOOT: begin
                    r = level;
                    g = level;
                    b = level;
                end
                M_IDLE: begin
                    b = level;
                end
                M_STARTING, M_WAYPOINT: begin
                    r = 8'd255;
                    g = 8'd255;
                    b = 8'd255;
                    if ((i % 2) == 1 && (el % FLASH_CYCLE) < FLASH_LIT) begin
                        if (ring_mode == M_STARTING) begin
                            r = 8'd0;
                            g = 8'd220;
                            b = 8'd0;
                        end else begin
                            r = 8'd255;
                            g = 8'd200;
                            b = 8'd0;
                        end
                    end
                end
                M_RUN: begin
                    r = 8'd255;
                    g = 8'd255;
                    b = 8'd255;
                end
                M_ERROR: begin
                    r = (((el / BLINK_STEP) % 2) == 0) ? 8'd255 : 8'd0;
                end
                M_MANUAL: begin
                    if (hand_pattern == 8'd0) begin
                        lit = 1'b1;
                    end else if (hand_pattern == 8'd1) begin
                        lit = ((el / BLINK_STEP) % 2) == 0;
                    end else begin
                        lit = ((el / CHASE_PERIOD) % LED_COUNT) == i;
                    end
                    r = lit ? hand_red : 8'd0;
                    g = lit ? hand_green : 8'd0;
                    b = lit ? hand_blue : 8'd0;
                end
                default: begin
                end
            endcase
            col.led_index     = 4'(i);
            col.red_out       = r;
            col.green_out     = g;
            col.blue_out      = b;
            col.last          = (i == LED_COUNT - 1);
            col.gate_deadline = sensor_gate_ms;
            colour_q.push_back(col);
        end
    endtask

    // Counts a failure and reports the first few of them.
    function automatic void report_fault(input string what, input t_out_item due,
                                         input t_out_item got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t ns %s: expected led %0d rgb %02h %02h %02h last %0b gate %08h",
                     $time, what, due.led_index, due.red_out, due.green_out, due.blue_out,
                     due.last, due.gate_deadline);
            $display("    got led %0d rgb %02h %02h %02h last %0b gate %08h",
                     got.led_index, got.red_out, got.green_out, got.blue_out,
                     got.last, got.gate_deadline);
        end
    endfunction

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_mode      = M_BOOT;
            mode_since_ms  = '0;
            last_tick_ms   = '0;
            sensor_gate_ms = '0;
            want_active    = 1'b0;
            want_error     = 1'b0;
            hand_red       = '0;
            hand_green     = '0;
            hand_blue      = '0;
            hand_pattern   = '0;
            colour_q.delete();
            o_fail_count   = 0;
            o_checked      = 0;
            o_frames       = 0;
        end else begin
            if (i_led_ch.valid === 1'b1 && i_led_ch.ready === 1'b1) begin
                got_colour = i_led_ch.data;
                if (colour_q.size() == 0) begin
                    report_fault("colour with none expected", '0, got_colour);
                end else begin
                    due_colour = colour_q.pop_front();
                    o_checked++;
                    if (got_colour.last === 1'b1) begin
                        o_frames++;
                    end
                    if (got_colour !== due_colour) begin
                        report_fault("colour mismatch", due_colour, got_colour);
                    end
                end
            end
            if (i_req_ch.valid === 1'b1 && i_req_ch.ready === 1'b1) begin
                predict_request(i_req_ch.data);
            end
        end
        o_pending = colour_q.size();
    end

endmodule

// File: tb/sv/led_ring_status_animator_top_test.sv
`timescale 1ns / 1ps

// Drives requests into the LED ring animator, stalls the colour output at
// random and gives the verdict from the failure count of the checker.
module led_ring_status_animator_top_test;
    import lra_pkg::*;

    localparam int         LED_COUNT = 16;
    localparam logic [2:0] A_UNUSED  = 3'd7;
    localparam int         IDLE_PCT  = 23;

    logic        i_clk;
    logic        i_rst_n;
    bit          steady_run;
    int          fail_count;
    int          pending;
    int          checked;
    int          frames;
    int          n_ticks;
    int          n_events;
    logic [31:0] clock_ms;

    lra_in_if  req_ch ();
    lra_out_if led_ch ();

    led_ring_status_animator_top #(
        .LED_COUNT (LED_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (led_ch)
    );

    led_ring_status_animator_checker #(
        .LED_COUNT (LED_COUNT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_ch     (req_ch),
        .i_led_ch     (led_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_frames     (frames)
    );

    // 4 ns clock.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // The colour receiver stalls at random, except during the steady stretch.
    always @(negedge i_clk) begin
        led_ch.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Hard limit on the run time.
    initial begin
        #2_000_000;
        $display("** led_ring_status_animator_top: FAILED **");
        $finish;
    end

    // Offers one request, after an optional random gap, and waits until it is taken.
    task automatic send_req(input logic [2:0] action, input logic [31:0] now,
                            input logic flag, input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic [7:0] pat,
                            input logic [2:0] fmode);
        t_in_item req;
        req.action      = action;
        req.now_ms      = now;
        req.flag        = flag;
        req.red_in      = red;
        req.green_in    = green;
        req.blue_in     = blue;
        req.pattern     = pat;
        req.forced_mode = fmode;
        if (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= req;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        if (action == A_TICK) begin
            n_ticks++;
        end else begin
            n_events++;
        end
    endtask

    // Holds the sender back until every expected colour has arrived.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int          pick;
        int          sel;
        logic [2:0]  act;
        logic        flag;
        logic [7:0]  pat;

        i_rst_n      = 1'b0;
        steady_run   = 1'b0;
        n_ticks      = 0;
        n_events     = 0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        led_ch.ready = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed walk through the modes. The first tick falls within 16 ms of
        // time zero and is dropped; the one at 16 ms draws a frame.
        send_req(A_TICK,         32'd0,    1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_TICK,         32'd16,   1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_SET_ACTIVE,   32'd20,   1'b1, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_TICK,         32'd400,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        // Boot runs out with the active wish set and moves to starting.
        send_req(A_TICK,         32'd800,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_TICK,         32'd830,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_WAYPOINT,     32'd970,  1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_TICK,         32'd1000, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        // Waypoint runs out into run.
        send_req(A_TICK,         32'd2000, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_SET_ACTIVE,   32'd2030, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_TICK,         32'd2100, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_SET_ACTIVE,   32'd2110, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_SET_ERROR,    32'd2120, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_TICK,         32'd2400, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        // A waypoint in error is ignored; clearing the error returns to run.
        send_req(A_WAYPOINT,     32'd2410, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_SET_ERROR,    32'd2420, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_SET_MANUAL,   32'd2430, 1'b0, 8'hFF, 8'h00, 8'hFF, 8'h02, M_OFF);
        send_req(A_TICK,         32'd2600, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        // An error wish in manual is stored only; clearing manual then enters error.
        send_req(A_SET_ERROR,    32'd2610, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_CLEAR_MANUAL, 32'd2620, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_FORCE_MODE,   32'd2630, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_TICK,         32'd2700, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_UNUSED,       32'd2710, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, M_MANUAL);
        // Near the top of the time range the gate deadline wraps.
        send_req(A_FORCE_MODE,   32'hFFFF_FF00, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_WAYPOINT);
        send_req(A_TICK,         32'hFFFF_FFFF, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        send_req(A_SET_MANUAL,   32'hFFFF_FFFF, 1'b0, 8'h00, 8'hFF, 8'h00, 8'h00, M_OFF);
        send_req(A_TICK,         32'h0000_0010, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, M_OFF);
        clock_ms = 32'h0000_0020;

        // Random part: mostly ticks at a realistic spacing mixed with events,
        // with occasional jumps anywhere in the time range.
        for (int k = 0; k < 160; k++) begin
            steady_run = (k >= 100 && k < 140);
            if (k == 80) begin
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                clock_ms = $urandom();
            end else if (pick < 6) begin
                clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 600));
            end
            flag = 1'b0;
            pat  = $urandom();
            if (pick < 60) begin
                act = A_TICK;
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    clock_ms = clock_ms + 32'($urandom_range(0, 15));
                end else if (sel == 1) begin
                    clock_ms = clock_ms + 32'($urandom_range(100, 1200));
                end else begin
                    clock_ms = clock_ms + 32'($urandom_range(16, 80));
                end
            end else begin
                clock_ms = clock_ms + 32'($urandom_range(0, 30));
                if (pick < 70) begin
                    act  = A_SET_ACTIVE;
                    flag = ($urandom_range(0, 99) < 60);
                end else if (pick < 78) begin
                    act  = A_SET_ERROR;
                    flag = ($urandom_range(0, 99) < 40);
                end else if (pick < 84) begin
                    act = A_WAYPOINT;
                end else if (pick < 90) begin
                    act = A_SET_MANUAL;
                    sel = $urandom_range(0, 3);
                    if (sel == 0) begin
                        pat = 8'd0;
                    end else if (sel == 1) begin
                        pat = 8'd1;
                    end
                end else if (pick < 95) begin
                    act = A_CLEAR_MANUAL;
                end else if (pick < 99) begin
                    act = A_FORCE_MODE;
                end else begin
                    act = A_UNUSED;
                end
                if (act != A_SET_ACTIVE && act != A_SET_ERROR) begin
                    flag = $urandom_range(0, 1);
                end
            end
            send_req(act, clock_ms, flag, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                     pat, 3'($urandom_range(0, 7)));
        end

        // Let the last frames drain, then allow for a late extra colour.
        steady_run = 1'b0;
        wait_drained();
        repeat (64) @(negedge i_clk);

        $display("Sent %0d requests (%0d ticks, %0d events); checked %0d LED colours in %0d frames.",
                 n_ticks + n_events, n_ticks, n_events, checked, frames);
        if (fail_count == 0 && pending == 0) begin
            $display("** led_ring_status_animator_top: PASSED **");
        end else begin
            $display("** led_ring_status_animator_top: FAILED **");
        end
        $finish;
    end

endmodule
